>>> sv/dependency_graph_topo_engine_top_assert.svh
// Assertion macros for the graph engine checker
`ifndef DEPENDENCY_GRAPH_TOPO_ENGINE_TOP_ASSERT_SVH
`define DEPENDENCY_GRAPH_TOPO_ENGINE_TOP_ASSERT_SVH

// checked only out of reset
`define DGTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define DGTE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/dgte_pkg.sv
package dgte_pkg;

  localparam int DEF_MAX_NODES  = 32;
  localparam int DEF_MAX_FANOUT = 8;

  localparam int KEY_W     = 32;
  localparam int IDX_IN_W  = 6;
  localparam int IDX_OUT_W = 5;
  localparam int FUNC_W    = 2;
  localparam int ST_W      = 2;
  localparam int IN_DW     = 48;
  localparam int OUT_DW    = 40;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_ADD_NODE,
    F_ADD_EDGE,
    F_ORDER
  } func_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_CYCLE,
    ST_FULL
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_CLEAR, S_KRD, S_KCMP, S_ECHK, S_WPOP, S_WCUR, S_WCNT,
    S_WSLOT, S_WPRED, S_CWAIT, S_OSTART, S_LRD, S_LWR, S_FRD, S_FCUR, S_FKEY,
    S_SSLOT, S_SD, S_SP, S_OEMIT, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLEAR, OP_ADDNODE, OP_KRD, OP_KHIT, OP_KNEXT,
    OP_RES_INV, OP_WINIT, OP_POP, OP_PCRD, OP_LDCNT, OP_PLRD, OP_PUSH, OP_CRD,
    OP_RES_CYC, OP_RES_FULL, OP_LINK, OP_OINIT, OP_LCRD, OP_LWR, OP_FRD,
    OP_KCRD, OP_LDKEY, OP_SLRD, OP_PDRD, OP_SKIP, OP_PDEC, OP_OEMIT, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_t;

  typedef struct packed {
    func_t func;
    logic  scan_end;
    logic  key_hit;
    logic  full;
    logic  edge_bad;
    logic  sp_zero;
    logic  cur_is_to;
    logic  slot_end;
    logic  lists_full;
    logic  n_zero;
    logic  fifo_empty;
    logic  succ_bad;
    logic  out_free;
  } stat_t;

endpackage

>>> sv/dgte_ctrl.sv
module dgte_ctrl import dgte_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl.op   = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.op   = OP_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.func)
          F_CLEAR:    state_nxt = S_CLEAR;
          F_ADD_NODE: state_nxt = S_KRD;
          F_ADD_EDGE: state_nxt = S_ECHK;
          F_ORDER:    state_nxt = S_OSTART;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_CLEAR: begin
        ctrl.op   = OP_CLEAR;
        state_nxt = S_EMIT;
      end
      S_KRD: begin
        if (stat.scan_end) begin
          ctrl.op   = OP_ADDNODE;
          state_nxt = S_EMIT;
        end else begin
          ctrl.op   = OP_KRD;
          state_nxt = S_KCMP;
        end
      end
      S_KCMP: begin
        if (stat.key_hit) begin
          ctrl.op   = OP_KHIT;
          state_nxt = S_EMIT;
        end else begin
          ctrl.op   = OP_KNEXT;
          state_nxt = S_KRD;
        end
      end
      S_ECHK: begin
        if (stat.edge_bad) begin
          ctrl.op   = OP_RES_INV;
          state_nxt = S_EMIT;
        end else begin
          ctrl.op   = OP_WINIT;
          state_nxt = S_WPOP;
        end
      end
      S_WPOP: begin
        if (stat.sp_zero) begin
          ctrl.op   = OP_CRD;
          state_nxt = S_CWAIT;
        end else begin
          ctrl.op   = OP_POP;
          state_nxt = S_WCUR;
        end
      end
      S_WCUR: begin
        if (stat.cur_is_to) begin
          ctrl.op   = OP_RES_CYC;
          state_nxt = S_EMIT;
        end else begin
          ctrl.op   = OP_PCRD;
          state_nxt = S_WCNT;
        end
      end
      S_WCNT: begin
        ctrl.op   = OP_LDCNT;
        state_nxt = S_WSLOT;
      end
      S_WSLOT: begin
        if (stat.slot_end) begin
          state_nxt = S_WPOP;
        end else begin
          ctrl.op   = OP_PLRD;
          state_nxt = S_WPRED;
        end
      end
      S_WPRED: begin
        ctrl.op   = OP_PUSH;
        state_nxt = S_WSLOT;
      end
      S_CWAIT: begin
        ctrl.op   = stat.lists_full ? OP_RES_FULL : OP_LINK;
        state_nxt = S_EMIT;
      end
      S_OSTART: begin
        if (stat.n_zero) begin
          state_nxt = S_IDLE;
        end else begin
          ctrl.op   = OP_OINIT;
          state_nxt = S_LRD;
        end
      end
      S_LRD: begin
        if (stat.scan_end) begin
          state_nxt = S_FRD;
        end else begin
          ctrl.op   = OP_LCRD;
          state_nxt = S_LWR;
        end
      end
      S_LWR: begin
        ctrl.op   = OP_LWR;
        state_nxt = S_LRD;
      end
      S_FRD: begin
        if (stat.fifo_empty) begin
          state_nxt = S_IDLE;
        end else begin
          ctrl.op   = OP_FRD;
          state_nxt = S_FCUR;
        end
      end
      S_FCUR: begin
        ctrl.op   = OP_KCRD;
        state_nxt = S_FKEY;
      end
      S_FKEY: begin
        ctrl.op   = OP_LDKEY;
        state_nxt = S_SSLOT;
      end
      S_SSLOT: begin
        if (stat.slot_end) begin
          state_nxt = S_OEMIT;
        end else begin
          ctrl.op   = OP_SLRD;
          state_nxt = S_SD;
        end
      end
      S_SD: begin
        if (stat.succ_bad) begin
          ctrl.op   = OP_SKIP;
          state_nxt = S_SSLOT;
        end else begin
          ctrl.op   = OP_PDRD;
          state_nxt = S_SP;
        end
      end
      S_SP: begin
        ctrl.op   = OP_PDEC;
        state_nxt = S_SSLOT;
      end
      S_OEMIT: begin
        if (stat.out_free) begin
          ctrl.op   = OP_OEMIT;
          state_nxt = stat.fifo_empty ? S_IDLE : S_FRD;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctrl.op   = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> sv/dgte_dpath.sv
module dgte_dpath import dgte_pkg::*; #(
  parameter int MAX_NODES  = DEF_MAX_NODES,
  parameter int MAX_FANOUT = DEF_MAX_FANOUT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                ctrl,
  output stat_t                stat,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [IDX_IN_W-1:0]  in_from,
  input  logic [IDX_IN_W-1:0]  in_to,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [ST_W-1:0]      out_status,
  output logic [IDX_OUT_W-1:0] out_index,
  output logic [KEY_W-1:0]     out_key,
  output logic                 out_last
);

  localparam int NIW = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int SW  = (MAX_FANOUT > 1) ? $clog2(MAX_FANOUT) : 1;
  localparam int FW  = $clog2(MAX_FANOUT + 1);
  localparam int LD  = 1 << (NIW + SW);

  // memories
  logic [KEY_W-1:0] key_mem_r  [MAX_NODES];
  logic [NIW-1:0]   succ_mem_r [LD];
  logic [NIW-1:0]   pred_mem_r [LD];
  logic [FW-1:0]    scnt_mem_r [MAX_NODES];
  logic [FW-1:0]    pcnt_mem_r [MAX_NODES];
  logic [FW-1:0]    pend_mem_r [MAX_NODES];
  logic [NIW-1:0]   stk_mem_r  [MAX_NODES];
  logic [NIW-1:0]   fifo_mem_r [MAX_NODES];

  logic [KEY_W-1:0] key_rd_r;
  logic [NIW-1:0]   succ_rd_r, pred_rd_r, stk_rd_r, fifo_rd_r;
  logic [FW-1:0]    scnt_rd_r, pcnt_rd_r, pend_rd_r;
  logic             scnt_rv_r, pcnt_rv_r;

  logic [MAX_NODES-1:0] scnt_v_r, pcnt_v_r, visited_r;

  func_t                func_r;
  logic [KEY_W-1:0]     key_r;
  logic [IDX_IN_W-1:0]  from_r, to_r;
  logic [CW-1:0]        n_r, i_r, sp_r, head_r, tail_r;
  logic [FW-1:0]        slot_r, cnt_r;
  logic [NIW-1:0]       cur_r, d_r, res_idx_r;
  status_t              res_st_r;
  logic [KEY_W-1:0]     res_key_r;

  logic                 out_valid_r, out_last_r;
  status_t              out_st_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [KEY_W-1:0]     out_key_r;

  logic [NIW-1:0]    from_i, to_i, key_ra, pc_ra, sc_ra, pend_ra;
  logic [NIW+SW-1:0] list_ra;
  logic [CW-1:0]     sp_m1;
  logic [FW-1:0]     scnt_val, pcnt_val;
  logic              p_ok, pend_push;
  dp_op_t            op;

  assign op       = ctrl.op;
  assign from_i   = from_r[NIW-1:0];
  assign to_i     = to_r[NIW-1:0];
  assign sp_m1    = sp_r - CW'(1);
  assign list_ra  = {cur_r, slot_r[SW-1:0]};
  assign scnt_val = scnt_rv_r ? scnt_rd_r : '0;
  assign pcnt_val = pcnt_rv_r ? pcnt_rd_r : '0;
  assign pend_ra  = succ_rd_r;

  assign p_ok = (8'(pred_rd_r) < 8'(MAX_NODES)) && !visited_r[pred_rd_r] &&
                (sp_r < CW'(MAX_NODES));
  assign pend_push = (pend_rd_r == FW'(1)) && (tail_r < CW'(MAX_NODES));

  always_comb begin
    key_ra = i_r[NIW-1:0];
    pc_ra  = to_i;
    sc_ra  = from_i;
    case (op)
      OP_KCRD: begin
        key_ra = fifo_rd_r;
        sc_ra  = fifo_rd_r;
      end
      OP_PCRD: pc_ra = stk_rd_r;
      OP_LCRD: pc_ra = i_r[NIW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    stat.func       = func_r;
    stat.scan_end   = (i_r == n_r);
    stat.key_hit    = (key_rd_r == key_r);
    stat.full       = (n_r == CW'(MAX_NODES));
    stat.edge_bad   = (8'(from_r) >= 8'(n_r)) || (8'(to_r) >= 8'(n_r)) || (from_r == to_r);
    stat.sp_zero    = (sp_r == '0);
    stat.cur_is_to  = (stk_rd_r == to_i);
    stat.slot_end   = (slot_r == cnt_r);
    stat.lists_full = (scnt_val >= FW'(MAX_FANOUT)) || (pcnt_val >= FW'(MAX_FANOUT));
    stat.n_zero     = (n_r == '0);
    stat.fifo_empty = (head_r == tail_r);
    stat.succ_bad   = (8'(succ_rd_r) >= 8'(n_r));
    stat.out_free   = !out_valid_r || out_ready;
  end

  // memory ports
  always_ff @(posedge clk) begin
    key_rd_r  <= key_mem_r[key_ra];
    succ_rd_r <= succ_mem_r[list_ra];
    pred_rd_r <= pred_mem_r[list_ra];
    scnt_rd_r <= scnt_mem_r[sc_ra];
    scnt_rv_r <= scnt_v_r[sc_ra];
    pcnt_rd_r <= pcnt_mem_r[pc_ra];
    pcnt_rv_r <= pcnt_v_r[pc_ra];
    pend_rd_r <= pend_mem_r[pend_ra];
    stk_rd_r  <= stk_mem_r[sp_m1[NIW-1:0]];
    fifo_rd_r <= fifo_mem_r[head_r[NIW-1:0]];

    if (op == OP_ADDNODE && !stat.full) begin
      key_mem_r[n_r[NIW-1:0]] <= key_r;
    end
    if (op == OP_LINK) begin
      pred_mem_r[{to_i, pcnt_val[SW-1:0]}]   <= from_i;
      pcnt_mem_r[to_i]                       <= pcnt_val + FW'(1);
      succ_mem_r[{from_i, scnt_val[SW-1:0]}] <= to_i;
      scnt_mem_r[from_i]                     <= scnt_val + FW'(1);
    end
    if (op == OP_WINIT) begin
      stk_mem_r[0] <= from_i;
    end
    if (op == OP_PUSH && p_ok) begin
      stk_mem_r[sp_r[NIW-1:0]] <= pred_rd_r;
    end
    if (op == OP_LWR) begin
      pend_mem_r[i_r[NIW-1:0]] <= pcnt_val;
      if (pcnt_val == '0) begin
        fifo_mem_r[tail_r[NIW-1:0]] <= i_r[NIW-1:0];
      end
    end
    if (op == OP_PDEC && pend_rd_r != '0) begin
      pend_mem_r[d_r] <= pend_rd_r - FW'(1);
      if (pend_push) begin
        fifo_mem_r[tail_r[NIW-1:0]] <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      sp_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      scnt_v_r    <= '0;
      pcnt_v_r    <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_OEMIT || op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        OP_LATCH: begin
          func_r <= func_t'(in_func);
          key_r  <= in_key;
          from_r <= in_from;
          to_r   <= in_to;
          i_r    <= '0;
        end
        OP_CLEAR: begin
          n_r       <= '0;
          scnt_v_r  <= '0;
          pcnt_v_r  <= '0;
          res_st_r  <= ST_OK;
          res_idx_r <= '0;
        end
        OP_ADDNODE: begin
          if (stat.full) begin
            res_st_r  <= ST_FULL;
            res_idx_r <= '0;
          end else begin
            res_st_r                  <= ST_OK;
            res_idx_r                 <= n_r[NIW-1:0];
            n_r                       <= n_r + CW'(1);
            scnt_v_r[n_r[NIW-1:0]]    <= 1'b0;
            pcnt_v_r[n_r[NIW-1:0]]    <= 1'b0;
          end
        end
        OP_KHIT: begin
          res_st_r  <= ST_OK;
          res_idx_r <= i_r[NIW-1:0];
        end
        OP_KNEXT: i_r <= i_r + CW'(1);
        OP_RES_INV: begin
          res_st_r  <= ST_INVALID;
          res_idx_r <= '0;
        end
        OP_WINIT: begin
          visited_r <= MAX_NODES'(1) << from_i;
          sp_r      <= CW'(1);
        end
        OP_POP:  sp_r  <= sp_m1;
        OP_PCRD: cur_r <= stk_rd_r;
        OP_LDCNT: begin
          cnt_r  <= pcnt_val;
          slot_r <= '0;
        end
        OP_PUSH: begin
          if (p_ok) begin
            visited_r[pred_rd_r] <= 1'b1;
            sp_r                 <= sp_r + CW'(1);
          end
          slot_r <= slot_r + FW'(1);
        end
        OP_RES_CYC: begin
          res_st_r  <= ST_CYCLE;
          res_idx_r <= '0;
        end
        OP_RES_FULL: begin
          res_st_r  <= ST_FULL;
          res_idx_r <= '0;
        end
        OP_LINK: begin
          res_st_r         <= ST_OK;
          res_idx_r        <= '0;
          pcnt_v_r[to_i]   <= 1'b1;
          scnt_v_r[from_i] <= 1'b1;
        end
        OP_OINIT: begin
          i_r    <= '0;
          head_r <= '0;
          tail_r <= '0;
        end
        OP_LWR: begin
          if (pcnt_val == '0) begin
            tail_r <= tail_r + CW'(1);
          end
          i_r <= i_r + CW'(1);
        end
        OP_FRD:  head_r <= head_r + CW'(1);
        OP_KCRD: cur_r  <= fifo_rd_r;
        OP_LDKEY: begin
          res_key_r <= key_rd_r;
          cnt_r     <= scnt_val;
          slot_r    <= '0;
        end
        OP_PDRD: begin
          d_r    <= succ_rd_r;
          slot_r <= slot_r + FW'(1);
        end
        OP_SKIP: slot_r <= slot_r + FW'(1);
        OP_PDEC: begin
          if (pend_rd_r != '0 && pend_push) begin
            tail_r <= tail_r + CW'(1);
          end
        end
        OP_OEMIT: begin
          out_st_r    <= ST_OK;
          out_idx_r   <= '0;
          out_key_r   <= res_key_r;
          out_last_r  <= stat.fifo_empty;
        end
        OP_EMIT: begin
          out_st_r    <= res_st_r;
          out_idx_r   <= IDX_OUT_W'(res_idx_r);
          out_key_r   <= '0;
          out_last_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_st_r;
  assign out_index  = out_idx_r;
  assign out_key    = out_key_r;
  assign out_last   = out_last_r;

endmodule

>>> sv/dependency_graph_topo_engine_top.sv
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tuser func, tdata key/from/to
// out_     out  out_tvalid/out_tready tdata status/index/key, tlast last
//
// One request at a time. Add node scans the held keys, add edge walks the predecessor lists
// from the source node, and ordering scans the count memory and then each successor list,
// so their running time grows with the graph held. The key, list and count memories each
// have a single read port.
// rst_n is synchronous; it empties the graph at once, with no clearing pass.
// A held result stalls only the next result; a new request is taken meanwhile.
module dependency_graph_topo_engine_top import dgte_pkg::*; #(
  parameter int MAX_NODES  = DEF_MAX_NODES,
  parameter int MAX_FANOUT = DEF_MAX_FANOUT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // task_key[31:0], from_node[37:32], to_node[43:38]
  input  logic [FUNC_W-1:0] in_tuser,   // func[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // status[1:0], node_index[6:2], order_key[38:7]
  output logic              out_tlast
);

  ctrl_t                ctrl;
  stat_t                stat;
  logic [ST_W-1:0]      st;
  logic [IDX_OUT_W-1:0] idx;
  logic [KEY_W-1:0]     okey;

  dgte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dgte_dpath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_FANOUT (MAX_FANOUT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_func    (in_tuser),
    .in_key     (in_tdata[31:0]),
    .in_from    (in_tdata[37:32]),
    .in_to      (in_tdata[43:38]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (st),
    .out_index  (idx),
    .out_key    (okey),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, okey, idx, st};

endmodule

>>> sv/dgte_checker.sv
`include "dependency_graph_topo_engine_top_assert.svh"

module dgte_checker import dgte_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tlast
);

  // a stalled result holds
  `DGTE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // one request at a time
  `DGTE_ASSERT(a_busy, in_tvalid && in_tready |=> !in_tready, "request taken while busy")

  `DGTE_ASSERT(a_pad, out_tvalid |-> !out_tdata[39], "padding bit set")

  // index and order key never both set
  `DGTE_ASSERT(a_idx_key, out_tvalid && out_tdata[6:2] != 5'd0 |-> out_tdata[38:7] == 32'd0, "index and key both set")

  `DGTE_ASSERT_RST(a_rst, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind dependency_graph_topo_engine_top dgte_checker u_chk (.*);
